// ===== hw/rtl/hsv2rgb_pkg.sv =====
// Shared constants and types for the HSV to RGB converter.
package hsv2rgb_pkg;

   localparam int FRAC_BITS_DEFAULT = 15;
   localparam int FIELD_W           = 16;

   // hue*6 integer part that means a full turn, folded back to sector zero
   localparam logic [2:0] SECTOR_WRAP = 3'd6;

   typedef enum logic [2:0] {
      SECTOR_0 = 3'd0,
      SECTOR_1 = 3'd1,
      SECTOR_2 = 3'd2,
      SECTOR_3 = 3'd3,
      SECTOR_4 = 3'd4,
      SECTOR_5 = 3'd5
   } sector_type;

endpackage

// ===== hw/rtl/hsv2rgb_prep.sv =====
// Stage 1: input clamp to 1.0, hue*6 split into sector and fraction.
module hsv2rgb_prep
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  logic [FIELD_W-1:0]   hue,
   input  logic [FIELD_W-1:0]   saturation,
   input  logic [FIELD_W-1:0]   brightness,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output sector_type           sector,
   output logic [FRAC_BITS-1:0] frac,
   output logic [FRAC_BITS:0]   sat,
   output logic [FRAC_BITS:0]   val
);

   localparam int VW = FRAC_BITS + 1;
   localparam int CW = (VW > FIELD_W) ? VW : FIELD_W;
   localparam int HW = FRAC_BITS + 4;
   localparam logic [CW-1:0] ONE_C = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [CW-1:0]        hue_c, sat_c, val_c;
   logic [VW-1:0]        hue_sat;
   logic [HW-1:0]        hue6;
   logic [2:0]           sector_raw;
   logic                 valid_ff;
   logic                 load;
   sector_type           sector_in, sector_ff;
   logic [FRAC_BITS-1:0] frac_in, frac_ff;
   logic [VW-1:0]        sat_in, sat_ff;
   logic [VW-1:0]        val_in, val_ff;

   always_comb begin
      hue_c   = CW'(hue);
      sat_c   = CW'(saturation);
      val_c   = CW'(brightness);
      hue_sat = (hue_c > ONE_C) ? VW'(ONE_C) : VW'(hue_c);
      sat_in  = (sat_c > ONE_C) ? VW'(ONE_C) : VW'(sat_c);
      val_in  = (val_c > ONE_C) ? VW'(ONE_C) : VW'(val_c);
      // 6h = 4h + 2h
      hue6       = HW'({hue_sat, 2'b00}) + HW'({hue_sat, 1'b0});
      sector_raw = hue6[FRAC_BITS+2:FRAC_BITS];
      frac_in    = hue6[FRAC_BITS-1:0];
      sector_in  = (sector_raw == SECTOR_WRAP) ? SECTOR_0 : sector_type'(sector_raw);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector_in;
         frac_ff   <= frac_in;
         sat_ff    <= sat_in;
         val_ff    <= val_in;
      end
   end

   assign dn_valid = valid_ff;
   assign sector   = sector_ff;
   assign frac     = frac_ff;
   assign sat      = sat_ff;
   assign val      = val_ff;

endmodule

// ===== hw/rtl/hsv2rgb_factor.sv =====
// Stage 2: scale factors 1-s, 1-f*s and 1-(1-f)*s.
module hsv2rgb_factor
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  sector_type           sector,
   input  logic [FRAC_BITS-1:0] frac,
   input  logic [FRAC_BITS:0]   sat,
   input  logic [FRAC_BITS:0]   val,
   output logic                 dn_valid,
   input  logic                 dn_ready,
   output sector_type           sector_o,
   output logic [FRAC_BITS:0]   kp,
   output logic [FRAC_BITS:0]   kq,
   output logic [FRAC_BITS:0]   kt,
   output logic [FRAC_BITS:0]   val_o
);

   localparam int VW = FRAC_BITS + 1;
   localparam int PW = FRAC_BITS + VW;
   localparam logic [VW-1:0] ONE_V = {{(VW-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic [VW-1:0] one_minus_f;
   logic [PW-1:0] fs_prod, ofs_prod;
   logic          valid_ff;
   logic          load;
   sector_type    sector_ff;
   logic [VW-1:0] kp_in, kq_in, kt_in;
   logic [VW-1:0] kp_ff, kq_ff, kt_ff, val_ff;

   always_comb begin
      one_minus_f = ONE_V - VW'(frac);
      fs_prod     = PW'(frac) * PW'(sat);
      ofs_prod    = PW'(one_minus_f) * PW'(sat);
      kp_in       = ONE_V - sat;
      kq_in       = ONE_V - fs_prod[PW-1:FRAC_BITS];
      kt_in       = ONE_V - ofs_prod[PW-1:FRAC_BITS];
   end

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector;
         kp_ff     <= kp_in;
         kq_ff     <= kq_in;
         kt_ff     <= kt_in;
         val_ff    <= val;
      end
   end

   assign dn_valid = valid_ff;
   assign sector_o = sector_ff;
   assign kp       = kp_ff;
   assign kq       = kq_ff;
   assign kt       = kt_ff;
   assign val_o    = val_ff;

endmodule

// ===== hw/rtl/hsv2rgb_scale.sv =====
// Stage 3: p, q and t as v times each factor, truncated.
module hsv2rgb_scale
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  sector_type         sector,
   input  logic [FRAC_BITS:0] kp,
   input  logic [FRAC_BITS:0] kq,
   input  logic [FRAC_BITS:0] kt,
   input  logic [FRAC_BITS:0] val,
   output logic               dn_valid,
   input  logic               dn_ready,
   output sector_type         sector_o,
   output logic [FRAC_BITS:0] p,
   output logic [FRAC_BITS:0] q,
   output logic [FRAC_BITS:0] t,
   output logic [FRAC_BITS:0] val_o
);

   localparam int VW = FRAC_BITS + 1;
   localparam int PW = 2 * VW;

   logic [PW-1:0] p_prod, q_prod, t_prod;
   logic          valid_ff;
   logic          load;
   sector_type    sector_ff;
   logic [VW-1:0] p_ff, q_ff, t_ff, val_ff;

   // factors never exceed 1.0, so each product shifted down fits in VW bits
   always_comb begin
      p_prod = PW'(val) * PW'(kp);
      q_prod = PW'(val) * PW'(kq);
      t_prod = PW'(val) * PW'(kt);
   end

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sector_ff <= sector;
         p_ff      <= p_prod[FRAC_BITS+VW-1:FRAC_BITS];
         q_ff      <= q_prod[FRAC_BITS+VW-1:FRAC_BITS];
         t_ff      <= t_prod[FRAC_BITS+VW-1:FRAC_BITS];
         val_ff    <= val;
      end
   end

   assign dn_valid = valid_ff;
   assign sector_o = sector_ff;
   assign p        = p_ff;
   assign q        = q_ff;
   assign t        = t_ff;
   assign val_o    = val_ff;

   a_p_le_v: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (p_ff <= val_ff))
      else $error("p above v");
   a_q_le_v: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (q_ff <= val_ff))
      else $error("q above v");
   a_t_le_v: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (t_ff <= val_ff))
      else $error("t above v");

endmodule

// ===== hw/rtl/hsv2rgb_select.sv =====
// Stage 4: sector permutation of v, p, q, t into the output register.
module hsv2rgb_select
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               up_valid,
   output logic               up_ready,
   input  sector_type         sector,
   input  logic [FRAC_BITS:0] p,
   input  logic [FRAC_BITS:0] q,
   input  logic [FRAC_BITS:0] t,
   input  logic [FRAC_BITS:0] val,
   output logic               dn_valid,
   input  logic               dn_ready,
   output logic [FIELD_W-1:0] red,
   output logic [FIELD_W-1:0] green,
   output logic [FIELD_W-1:0] blue
);

   localparam int VW = FRAC_BITS + 1;

   logic [VW-1:0]      r_sel, g_sel, b_sel;
   logic               valid_ff;
   logic               load;
   logic [FIELD_W-1:0] red_ff, green_ff, blue_ff;

   always_comb begin
      case (sector)
         SECTOR_0: begin
            r_sel = val; g_sel = t;   b_sel = p;
         end
         SECTOR_1: begin
            r_sel = q;   g_sel = val; b_sel = p;
         end
         SECTOR_2: begin
            r_sel = p;   g_sel = val; b_sel = t;
         end
         SECTOR_3: begin
            r_sel = p;   g_sel = q;   b_sel = val;
         end
         SECTOR_4: begin
            r_sel = t;   g_sel = p;   b_sel = val;
         end
         default: begin
            r_sel = val; g_sel = p;   b_sel = q;
         end
      endcase
   end

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         red_ff   <= FIELD_W'(r_sel);
         green_ff <= FIELD_W'(g_sel);
         blue_ff  <= FIELD_W'(b_sel);
      end
   end

   assign dn_valid = valid_ff;
   assign red      = red_ff;
   assign green    = green_ff;
   assign blue     = blue_ff;

endmodule

// ===== hw/rtl/hsv_to_rgb_converter_top.sv =====
// Pipeline: an accepted request passes through four register stages (clamp/sector, factors,
//   scaling multiplies, permutation) before it shows on rsp_*.
// Throughput: one request per cycle while rsp_stall is low; each stage advances whenever it
//   is empty or the stage after it moves, so bubbles are squeezed out under rsp_stall.
// Reset: synchronous, active high; clears all stage valid bits, data is not reset.
module hsv_to_rgb_converter_top
   import hsv2rgb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_hue,
   input  logic [FIELD_W-1:0] req_saturation,
   input  logic [FIELD_W-1:0] req_brightness,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_red,
   output logic [FIELD_W-1:0] rsp_green,
   output logic [FIELD_W-1:0] rsp_blue
);

   logic                 prep_up_ready, prep_valid;
   logic                 fact_up_ready, fact_valid;
   logic                 scale_up_ready, scale_valid;
   logic                 sel_up_ready;
   sector_type           prep_sector, fact_sector, scale_sector;
   logic [FRAC_BITS-1:0] prep_frac;
   logic [FRAC_BITS:0]   prep_sat, prep_val;
   logic [FRAC_BITS:0]   fact_kp, fact_kq, fact_kt, fact_val;
   logic [FRAC_BITS:0]   scale_p, scale_q, scale_t, scale_val;

   assign req_stall = !prep_up_ready;

   hsv2rgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_valid),
      .up_ready   (prep_up_ready),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .dn_valid   (prep_valid),
      .dn_ready   (fact_up_ready),
      .sector     (prep_sector),
      .frac       (prep_frac),
      .sat        (prep_sat),
      .val        (prep_val)
   );

   hsv2rgb_factor #(.FRAC_BITS(FRAC_BITS)) u_factor (
      .clock    (clock),
      .reset    (reset),
      .up_valid (prep_valid),
      .up_ready (fact_up_ready),
      .sector   (prep_sector),
      .frac     (prep_frac),
      .sat      (prep_sat),
      .val      (prep_val),
      .dn_valid (fact_valid),
      .dn_ready (scale_up_ready),
      .sector_o (fact_sector),
      .kp       (fact_kp),
      .kq       (fact_kq),
      .kt       (fact_kt),
      .val_o    (fact_val)
   );

   hsv2rgb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
      .clock    (clock),
      .reset    (reset),
      .up_valid (fact_valid),
      .up_ready (scale_up_ready),
      .sector   (fact_sector),
      .kp       (fact_kp),
      .kq       (fact_kq),
      .kt       (fact_kt),
      .val      (fact_val),
      .dn_valid (scale_valid),
      .dn_ready (sel_up_ready),
      .sector_o (scale_sector),
      .p        (scale_p),
      .q        (scale_q),
      .t        (scale_t),
      .val_o    (scale_val)
   );

   hsv2rgb_select #(.FRAC_BITS(FRAC_BITS)) u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (scale_valid),
      .up_ready (sel_up_ready),
      .sector   (scale_sector),
      .p        (scale_p),
      .q        (scale_q),
      .t        (scale_t),
      .val      (scale_val),
      .dn_valid (rsp_valid),
      .dn_ready (!rsp_stall),
      .red      (rsp_red),
      .green    (rsp_green),
      .blue     (rsp_blue)
   );

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> prep_valid)
      else $error("accepted request missing from first stage");
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (prep_valid && fact_valid && scale_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while pipeline full and stalled");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_red) &&
                                    $stable(rsp_green) && $stable(rsp_blue)))
      else $error("stalled response changed");

endmodule
